// ----- rtl/dmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmpc_pkg: shared types and constants of the dual motor position controller
// Word layouts, register map, mode codes and the fixed-point divide constants.
// ----------------------------------------------------------------------------
package dmpc_pkg;

  localparam int NUM_MOTORS_DEF  = 2;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int DUTY_W  = 8;
  localparam int GAIN_W  = 16;
  localparam int TOL_W   = 8;
  localparam int CPR_W   = 16;
  localparam int ANGLE_W = 16;

  // angle * edges_per_turn stays below 2^31 in magnitude
  localparam int PROD_W = 32;

  // 5760 sixteenths of a degree per turn = 128 * 45
  localparam int          PRE_SHIFT   = 7;
  localparam int          SCALED_W    = PROD_W - 1 - PRE_SHIFT;
  localparam int          RECIP_K_W   = 25;
  localparam logic [24:0] RECIP_45    = 25'd23860930;
  localparam int          RECIP_SHIFT = 30;
  localparam int          RECIP_W     = SCALED_W + RECIP_K_W;
  localparam int          QUO_W       = RECIP_W - RECIP_SHIFT;
  localparam int          DELTA_W     = QUO_W + 1;

  // apb register map
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_GAIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOL     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CPR     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REV0    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REV1    = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd26214;
  localparam logic [DUTY_W-1:0] MAX_RST  = 8'd255;
  localparam logic [TOL_W-1:0]  TOL_RST  = 8'd3;
  localparam logic [CPR_W-1:0]  CPR_RST  = 16'd4704;

  // item modes
  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic                      motor_sel;
    logic                      enc_b_level;
    logic signed [ANGLE_W-1:0] move_angle;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_motor0;
    logic [DUTY_W-1:0] duty_motor1;
    logic              fwd_motor0;
    logic              fwd_motor1;
    logic              driver_enable;
    logic              motion_done;
  } out_word_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_q16;
    logic [DUTY_W-1:0] max_duty;
    logic [TOL_W-1:0]  done_tolerance;
    logic [CPR_W-1:0]  edges_per_turn;
    logic              reverse_motor0;
    logic              reverse_motor1;
  } cfg_t;

  typedef struct packed {
    in_word_t                  item;
    logic signed [DELTA_W-1:0] delta;
  } exec_word_t;

endpackage

// ----- rtl/dmpc_regs.sv -----
// ----------------------------------------------------------------------------
// dmpc_regs: configuration registers
// APB write and read access to gain, duty limit, tolerance, scale and direction.
// ----------------------------------------------------------------------------
module dmpc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [dmpc_pkg::DATA_W-1:0]  pwdata,
  output logic [dmpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output dmpc_pkg::cfg_t               cfg
);

  dmpc_pkg::cfg_t                      cfg_r;
  logic                                wr_en;
  logic [dmpc_pkg::REG_IDX_W-1:0]      idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[dmpc_pkg::ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_q16       <= dmpc_pkg::GAIN_RST;
      cfg_r.max_duty       <= dmpc_pkg::MAX_RST;
      cfg_r.done_tolerance <= dmpc_pkg::TOL_RST;
      cfg_r.edges_per_turn <= dmpc_pkg::CPR_RST;
      cfg_r.reverse_motor0 <= 1'b0;
      cfg_r.reverse_motor1 <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        dmpc_pkg::REG_GAIN: cfg_r.gain_q16       <= pwdata[dmpc_pkg::GAIN_W-1:0];
        dmpc_pkg::REG_MAX:  cfg_r.max_duty       <= pwdata[dmpc_pkg::DUTY_W-1:0];
        dmpc_pkg::REG_TOL:  cfg_r.done_tolerance <= pwdata[dmpc_pkg::TOL_W-1:0];
        dmpc_pkg::REG_CPR:  cfg_r.edges_per_turn <= pwdata[dmpc_pkg::CPR_W-1:0];
        dmpc_pkg::REG_REV0: cfg_r.reverse_motor0 <= pwdata[0];
        dmpc_pkg::REG_REV1: cfg_r.reverse_motor1 <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      dmpc_pkg::REG_GAIN: prdata = dmpc_pkg::DATA_W'(cfg_r.gain_q16);
      dmpc_pkg::REG_MAX:  prdata = dmpc_pkg::DATA_W'(cfg_r.max_duty);
      dmpc_pkg::REG_TOL:  prdata = dmpc_pkg::DATA_W'(cfg_r.done_tolerance);
      dmpc_pkg::REG_CPR:  prdata = dmpc_pkg::DATA_W'(cfg_r.edges_per_turn);
      dmpc_pkg::REG_REV0: prdata = dmpc_pkg::DATA_W'(cfg_r.reverse_motor0);
      dmpc_pkg::REG_REV1: prdata = dmpc_pkg::DATA_W'(cfg_r.reverse_motor1);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- rtl/dmpc_offset.sv -----
// ----------------------------------------------------------------------------
// dmpc_offset: move offset pipeline
// Input register, then angle * edges_per_turn, reciprocal divide by 5760 and
// sign restore, one step per stage; every word rides along in order.
// ----------------------------------------------------------------------------
module dmpc_offset (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dmpc_pkg::in_word_t           in_data,
  input  logic [dmpc_pkg::CPR_W-1:0]   edges_per_turn,
  output logic                         ex_valid,
  input  logic                         ex_stall,
  output dmpc_pkg::exec_word_t         ex_data
);

  logic                                  v0_r, v1_r, v2_r, v3_r;
  logic                                  rdy0, rdy1, rdy2, rdy3;
  dmpc_pkg::in_word_t                    w0_r, w1_r, w2_r, w3_r;

  logic signed [dmpc_pkg::ANGLE_W+dmpc_pkg::CPR_W:0] prod_full;
  logic [dmpc_pkg::PROD_W-1:0]           prod_nxt, prod_r;
  logic [dmpc_pkg::PROD_W-1:0]           prod_mag;
  logic [dmpc_pkg::SCALED_W-1:0]         scaled;
  logic [dmpc_pkg::RECIP_W-1:0]          recip_nxt, recip_r;
  logic                                  neg_r;
  logic [dmpc_pkg::QUO_W-1:0]            quo;
  logic [dmpc_pkg::DELTA_W-1:0]          delta_nxt, delta_r;

  assign rdy3     = !v3_r || !ex_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;

  assign prod_full = w0_r.move_angle * $signed({1'b0, edges_per_turn});
  assign prod_nxt  = prod_full[dmpc_pkg::PROD_W-1:0];

  assign prod_mag  = prod_r[dmpc_pkg::PROD_W-1] ? (~prod_r + 1'b1) : prod_r;
  assign scaled    = prod_mag[dmpc_pkg::PROD_W-2:dmpc_pkg::PRE_SHIFT];
  assign recip_nxt = dmpc_pkg::RECIP_W'(scaled) * dmpc_pkg::RECIP_W'(dmpc_pkg::RECIP_45);

  assign quo       = recip_r[dmpc_pkg::RECIP_W-1:dmpc_pkg::RECIP_SHIFT];
  assign delta_nxt = neg_r ? (dmpc_pkg::DELTA_W'(0) - {1'b0, quo}) : {1'b0, quo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) w0_r <= in_data;
    if (rdy1 && v0_r) begin
      w1_r   <= w0_r;
      prod_r <= prod_nxt;
    end
    if (rdy2 && v1_r) begin
      w2_r    <= w1_r;
      recip_r <= recip_nxt;
      neg_r   <= prod_r[dmpc_pkg::PROD_W-1];
    end
    if (rdy3 && v2_r) begin
      w3_r    <= w2_r;
      delta_r <= delta_nxt;
    end
  end

  assign ex_valid      = v3_r;
  assign ex_data.item  = w3_r;
  assign ex_data.delta = delta_r;

endmodule

// ----- rtl/dmpc_exec.sv -----
// ----------------------------------------------------------------------------
// dmpc_exec: motor state and result register
// Tracks each motor's wrapped error and its magnitude, runs start, edge and
// tick updates, and holds the result word for the output side.
// ----------------------------------------------------------------------------
module dmpc_exec #(
  parameter int NUM_MOTORS  = dmpc_pkg::NUM_MOTORS_DEF,
  parameter int COUNT_WIDTH = dmpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ex_valid,
  output logic                  ex_stall,
  input  dmpc_pkg::exec_word_t  ex_data,
  input  dmpc_pkg::cfg_t        cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dmpc_pkg::out_word_t   out_data
);

  localparam int PG_W = COUNT_WIDTH + dmpc_pkg::GAIN_W;

  logic [COUNT_WIDTH-1:0]        err_r   [NUM_MOTORS];
  logic [COUNT_WIDTH-1:0]        err_nxt [NUM_MOTORS];
  logic [COUNT_WIDTH-1:0]        mag_r   [NUM_MOTORS];
  logic [COUNT_WIDTH-1:0]        mag_nxt [NUM_MOTORS];
  logic [dmpc_pkg::DUTY_W-1:0]   duty_r  [NUM_MOTORS];
  logic [dmpc_pkg::DUTY_W-1:0]   duty_nxt[NUM_MOTORS];
  logic [dmpc_pkg::DUTY_W-1:0]   duty_sat[NUM_MOTORS];
  logic [PG_W-1:0]               pgain   [NUM_MOTORS];
  logic [COUNT_WIDTH-1:0]        scaled  [NUM_MOTORS];
  logic [NUM_MOTORS-1:0]         pol_r, pol_nxt, rev_vec;
  logic                          enable_r, enable_nxt;
  logic                          moving_r, moving_nxt;
  logic                          done_nxt;
  logic                          arrived;
  logic                          duty_any;
  logic                          fire;
  logic [COUNT_WIDTH-1:0]        delta_w;
  logic                          out_valid_r;
  dmpc_pkg::out_word_t           out_r, out_nxt;

  assign ex_stall  = out_valid_r && out_stall;
  assign fire      = ex_valid && !ex_stall;
  assign delta_w   = COUNT_WIDTH'(ex_data.delta);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // per-motor error magnitude checks and duty from the registered magnitude
  always_comb begin
    arrived = 1'b1;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      rev_vec[m] = (m == 0) ? cfg.reverse_motor0 :
                   (m == 1) ? cfg.reverse_motor1 : 1'b0;
      if (mag_r[m] > COUNT_WIDTH'(cfg.done_tolerance)) arrived = 1'b0;
      pgain[m]  = PG_W'(mag_r[m]) * PG_W'(cfg.gain_q16);
      scaled[m] = pgain[m][PG_W-1:dmpc_pkg::GAIN_W];
      if (scaled[m] > COUNT_WIDTH'(cfg.max_duty)) begin
        duty_sat[m] = cfg.max_duty;
      end else begin
        duty_sat[m] = scaled[m][dmpc_pkg::DUTY_W-1:0];
      end
    end
  end

  always_comb begin
    err_nxt    = err_r;
    duty_nxt   = duty_r;
    pol_nxt    = pol_r;
    enable_nxt = enable_r;
    moving_nxt = moving_r;
    done_nxt   = 1'b0;
    unique case (ex_data.item.mode)
      dmpc_pkg::MODE_EDGE: begin
        for (int m = 0; m < NUM_MOTORS; m++) begin
          if (int'(ex_data.item.motor_sel) == m) begin
            err_nxt[m] = ex_data.item.enc_b_level ? (err_r[m] - COUNT_WIDTH'(1))
                                                  : (err_r[m] + COUNT_WIDTH'(1));
          end
        end
      end
      dmpc_pkg::MODE_START: begin
        enable_nxt = 1'b1;
        moving_nxt = 1'b1;
        for (int m = 0; m < NUM_MOTORS; m++) begin
          err_nxt[m] = rev_vec[m] ? (COUNT_WIDTH'(0) - delta_w) : delta_w;
          pol_nxt[m] = !rev_vec[m];
        end
      end
      dmpc_pkg::MODE_TICK: begin
        if (moving_r) begin
          if (arrived) begin
            for (int m = 0; m < NUM_MOTORS; m++) duty_nxt[m] = '0;
            enable_nxt = 1'b0;
            moving_nxt = 1'b0;
            done_nxt   = 1'b1;
          end else begin
            duty_nxt = duty_sat;
          end
        end
      end
      default: ;
    endcase
    for (int m = 0; m < NUM_MOTORS; m++) begin
      mag_nxt[m] = err_nxt[m][COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - err_nxt[m]) : err_nxt[m];
    end
  end

  always_comb begin
    out_nxt.duty_motor0   = duty_nxt[0];
    out_nxt.duty_motor1   = (NUM_MOTORS > 1) ? duty_nxt[1 % NUM_MOTORS] : '0;
    out_nxt.fwd_motor0    = pol_nxt[0];
    out_nxt.fwd_motor1    = (NUM_MOTORS > 1) ? pol_nxt[1 % NUM_MOTORS] : 1'b0;
    out_nxt.driver_enable = enable_nxt;
    out_nxt.motion_done   = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        err_r[m]  <= '0;
        mag_r[m]  <= '0;
        duty_r[m] <= '0;
      end
      pol_r       <= '0;
      enable_r    <= 1'b0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        err_r    <= err_nxt;
        mag_r    <= mag_nxt;
        duty_r   <= duty_nxt;
        pol_r    <= pol_nxt;
        enable_r <= enable_nxt;
        moving_r <= moving_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= out_nxt;
  end

  always_comb begin
    duty_any = 1'b0;
    for (int m = 0; m < NUM_MOTORS; m++) duty_any = duty_any | (|duty_r[m]);
  end

  a_enable_tracks_moving: assert property (@(posedge clk) disable iff (!rst_n)
    enable_r == moving_r)
    else $error("driver enable out of step with motion state");

  a_idle_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> !duty_any)
    else $error("nonzero duty while idle");

  a_stop_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(moving_r) |-> $past(fire && ex_data.item.mode == dmpc_pkg::MODE_TICK))
    else $error("motion ended without a tick");

  a_arrival_flags_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ex_data.item.mode == dmpc_pkg::MODE_TICK && moving_r && arrived
    |=> out_valid_r && out_r.motion_done && !out_r.driver_enable)
    else $error("arrival tick did not report done");

endmodule

// ----- rtl/dual_motor_position_p_controller_core.sv -----
// ----------------------------------------------------------------------------
// dual_motor_position_p_controller_core: two-motor proportional position loop
// Encoder edge counting, relative move start and proportional duty per tick.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall is low and returns one result word
// per input word, in order. Each word passes the move offset path (input
// register, angle times edges_per_turn, reciprocal divide by 5760, sign
// restore) and then the state stage, whose result register presents it. Every
// mode passes through the same stages, and the state stage applies an edge,
// start or tick as each word is accepted, so encoder edges and ticks may follow
// each other on every clock while nothing is stalled. The result register
// decouples the output: new words keep entering while a result waits, until
// the pipeline is full.
// Configuration is expected only while no word is in flight.
module dual_motor_position_p_controller_core #(
  parameter int NUM_MOTORS  = dmpc_pkg::NUM_MOTORS_DEF,
  parameter int COUNT_WIDTH = dmpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dmpc_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dmpc_pkg::out_word_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [dmpc_pkg::DATA_W-1:0]  pwdata,
  output logic [dmpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  dmpc_pkg::cfg_t        cfg;
  logic                  ex_valid;
  logic                  ex_stall;
  dmpc_pkg::exec_word_t  ex_data;

  dmpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmpc_offset u_offset (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .edges_per_turn (cfg.edges_per_turn),
    .ex_valid       (ex_valid),
    .ex_stall       (ex_stall),
    .ex_data        (ex_data)
  );

  dmpc_exec #(
    .NUM_MOTORS  (NUM_MOTORS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .ex_valid  (ex_valid),
    .ex_stall  (ex_stall),
    .ex_data   (ex_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
